FILE: src/scr_pkg.sv
// Shared constants and arithmetic helpers for the sensor raw compensation block.
// Used by the top level and the pipelined divider; depends on nothing.
`timescale 1ns / 1ps

package scr_pkg;

	// Register indexes of the configuration port (byte address / 8).
	localparam logic [2:0] REG_CAL_TEMP       = 3'd0;
	localparam logic [2:0] REG_CAL_PRESS_A    = 3'd1;
	localparam logic [2:0] REG_CAL_PRESS_B    = 3'd2;
	localparam logic [2:0] REG_CAL_PRESS_NINE = 3'd3;
	localparam logic [2:0] REG_CAL_HUM        = 3'd4;

	// Bits resolved by the divider, one per stage.
	localparam int DIV_BITS = 64;
	// Stage at which the divider takes its operands.
	localparam int DIV_IN_STAGE = 13;
	// Last pipeline stage; the output register follows it.
	localparam int PIPE_LAST = DIV_IN_STAGE + DIV_BITS + 6;

	function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned n);
		return $unsigned($signed(v) >>> n);
	endfunction

	function automatic logic [63:0] asr64(input logic [63:0] v, input int unsigned n);
		return $unsigned($signed(v) >>> n);
	endfunction

	function automatic logic [63:0] sx16_64(input logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	function automatic logic [31:0] sx16_32(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

endpackage

FILE: src/sensor_raw_compensation.sv
// Top level of the sensor raw compensation block: configuration registers,
// pipeline control and datapaths. Depends on scr_pkg, scr_mul64 and scr_div64.
//
//  channel  direction  handshake           payload
//  input    in         in_valid/in_stall   raw_temp, raw_press, raw_hum
//  result   out        out_valid/out_stall temp_centideg, press_q24_8, hum_q22_10
//  config   APB        psel/penable/pready paddr, pwdata, prdata (64-bit)
//
// One item enters per cycle while in_stall is low; its result passes the pipeline up to
// stage PIPE_LAST and then the output register, a depth set by the 64-stage pressure
// divider and the multiplier stages around it.
// Reset clears the valid bits, the output and skid valid flags and all calibration.
// A stalled result is caught in a one-item skid register; the pipeline freezes
// only while that register is full, and in_stall is taken from it directly.
`timescale 1ns / 1ps

module sensor_raw_compensation import scr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [19:0] raw_temp,
	input  logic [19:0] raw_press,
	input  logic [15:0] raw_hum,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] temp_centideg,
	output logic [31:0] press_q24_8,
	output logic [16:0] hum_q22_10
);

	// ---------------- configuration ----------------
	logic [47:0] cal_temp_q;
	logic [63:0] cal_press_a_q;
	logic [63:0] cal_press_b_q;
	logic [15:0] cal_press_nine_q;
	logic [63:0] cal_hum_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_temp_q       <= '0;
			cal_press_a_q    <= '0;
			cal_press_b_q    <= '0;
			cal_press_nine_q <= '0;
			cal_hum_q        <= '0;
		end else if (cfg_wr) begin
			case (paddr[5:3])
				REG_CAL_TEMP:       cal_temp_q       <= pwdata[47:0];
				REG_CAL_PRESS_A:    cal_press_a_q    <= pwdata;
				REG_CAL_PRESS_B:    cal_press_b_q    <= pwdata;
				REG_CAL_PRESS_NINE: cal_press_nine_q <= pwdata[15:0];
				REG_CAL_HUM:        cal_hum_q        <= pwdata;
				default:            ;
			endcase
		end
	end

	always_comb begin
		case (paddr[5:3])
			REG_CAL_TEMP:       prdata = {16'd0, cal_temp_q};
			REG_CAL_PRESS_A:    prdata = cal_press_a_q;
			REG_CAL_PRESS_B:    prdata = cal_press_b_q;
			REG_CAL_PRESS_NINE: prdata = {48'd0, cal_press_nine_q};
			REG_CAL_HUM:        prdata = cal_hum_q;
			default:            prdata = '0;
		endcase
	end

	logic [31:0] t1, t2, t3;
	logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
	logic [31:0] h1, h2, h3, h4, h5, h6;

	assign t1 = {16'd0, cal_temp_q[15:0]};
	assign t2 = sx16_32(cal_temp_q[31:16]);
	assign t3 = sx16_32(cal_temp_q[47:32]);
	assign p1 = {48'd0, cal_press_a_q[15:0]};
	assign p2 = sx16_64(cal_press_a_q[31:16]);
	assign p3 = sx16_64(cal_press_a_q[47:32]);
	assign p4 = sx16_64(cal_press_a_q[63:48]);
	assign p5 = sx16_64(cal_press_b_q[15:0]);
	assign p6 = sx16_64(cal_press_b_q[31:16]);
	assign p7 = sx16_64(cal_press_b_q[47:32]);
	assign p8 = sx16_64(cal_press_b_q[63:48]);
	assign p9 = sx16_64(cal_press_nine_q);
	assign h1 = {24'd0, cal_hum_q[7:0]};
	assign h2 = sx16_32(cal_hum_q[23:8]);
	assign h3 = {24'd0, cal_hum_q[31:24]};
	assign h4 = {20'd0, cal_hum_q[43:32]};
	assign h5 = {20'd0, cal_hum_q[55:44]};
	assign h6 = {{24{cal_hum_q[63]}}, cal_hum_q[63:56]};

	// ---------------- pipeline control ----------------
	logic              adv;
	logic [PIPE_LAST:1] vld_q;
	logic              skid_v_q;
	logic [31:0]       skid_temp_q;
	logic [31:0]       skid_press_q;
	logic [16:0]       skid_hum_q;
	logic              out_v_q;
	logic [31:0]       out_temp_q;
	logic [31:0]       out_press_q;
	logic [16:0]       out_hum_q;

	assign adv      = ~skid_v_q;
	assign in_stall = skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[PIPE_LAST-1:1], in_valid};
		end
	end

	// ---------------- temperature, stages 1 to 5 ----------------
	logic [31:0] d1_s1, d2_s1;
	logic [31:0] m1_s2, m2_s2;
	logic [31:0] va_s3, m3_s3;
	logic [31:0] tf_s4;
	logic [31:0] tf5;

	assign tf5 = tf_s4 * 32'd5 + 32'd128;

	always_ff @(posedge clk) begin
		if (adv) begin
			d1_s1 <= {15'd0, raw_temp[19:3]} - {t1[30:0], 1'b0};
			d2_s1 <= {16'd0, raw_temp[19:4]} - t1;
			m1_s2 <= d1_s1 * t2;
			m2_s2 <= d2_s1 * d2_s1;
			va_s3 <= asr32(m1_s2, 11);
			m3_s3 <= asr32(m2_s2, 12) * t3;
			tf_s4 <= va_s3 + asr32(m3_s3, 14);
		end
	end

	// Item fields that later stages need travel in delay lines.
	logic [31:0] temp_dly_q [5:PIPE_LAST];
	logic [20:0] pr_dly_q   [1:10];
	logic [15:0] hr_dly_q   [1:5];

	always_ff @(posedge clk) begin
		if (adv) begin
			temp_dly_q[5] <= asr32(tf5, 8);
			for (int k = 6; k <= PIPE_LAST; k++) begin
				temp_dly_q[k] <= temp_dly_q[k-1];
			end
			pr_dly_q[1] <= 21'd1048576 - {1'b0, raw_press};
			for (int k = 2; k <= 10; k++) begin
				pr_dly_q[k] <= pr_dly_q[k-1];
			end
			hr_dly_q[1] <= raw_hum;
			for (int k = 2; k <= 5; k++) begin
				hr_dly_q[k] <= hr_dly_q[k-1];
			end
		end
	end

	// ---------------- humidity, stages 5 to 11 ----------------
	logic [31:0] hv;
	logic [31:0] mh5_s5, mh6_s5, mh3_s5;
	logic [31:0] a_s6, bm_s6;
	logic [31:0] a_s7, bh_s7;
	logic [31:0] vv_s8, vv_s9, ss_s9, vv_s10, sh_s10;
	logic [31:0] hum_pre;
	logic [31:0] hv_fin;
	logic [16:0] hum_dly_q [11:PIPE_LAST];

	assign hv      = tf_s4 - 32'd76800;
	assign hum_pre = ({16'd0, hr_dly_q[5]} << 14) - (h4 << 20) - mh5_s5 + 32'd16384;
	assign hv_fin  = vv_s10 - asr32(sh_s10, 4);

	always_ff @(posedge clk) begin
		if (adv) begin
			mh5_s5 <= h5 * hv;
			mh6_s5 <= hv * h6;
			mh3_s5 <= hv * h3;
			a_s6   <= asr32(hum_pre, 15);
			bm_s6  <= asr32(mh6_s5, 10) * (asr32(mh3_s5, 11) + 32'd32768);
			a_s7   <= a_s6;
			bh_s7  <= (asr32(bm_s6, 10) + 32'd2097152) * h2;
			vv_s8  <= a_s7 * asr32(bh_s7 + 32'd8192, 14);
			vv_s9  <= vv_s8;
			ss_s9  <= asr32(vv_s8, 15) * asr32(vv_s8, 15);
			vv_s10 <= vv_s9;
			sh_s10 <= asr32(ss_s9, 7) * h1;
			// Negative values clamp to zero, large ones to the top of the range.
			if (hv_fin[31]) begin
				hum_dly_q[11] <= '0;
			end else if (hv_fin > 32'd419430400) begin
				hum_dly_q[11] <= 17'd102400;
			end else begin
				hum_dly_q[11] <= hv_fin[28:12];
			end
			for (int k = 12; k <= PIPE_LAST; k++) begin
				hum_dly_q[k] <= hum_dly_q[k-1];
			end
		end
	end

	// ---------------- pressure, stages 5 to 83 ----------------
	logic [63:0] x_s5;
	logic [63:0] xx_s7, xp5_s7, xp2_s7;
	logic [63:0] xp5_s8, xp2_s8, xp5_s9, xp2_s9;
	logic [63:0] xxp6_s9, xxp3_s9;
	logic [63:0] w2_s10, w1a_s10;
	logic [63:0] num0, w1s;
	logic [63:0] num_s12, w1r_s12;
	logic [63:0] w1;
	logic [63:0] ua_s13, ub_s13;
	logic        zero_dly_q [DIV_IN_STAGE:PIPE_LAST-1];
	logic        neg_dly_q  [DIV_IN_STAGE:DIV_IN_STAGE+DIV_BITS];
	logic [63:0] uq;
	logic [63:0] q_dly_q    [DIV_IN_STAGE+DIV_BITS+1:DIV_IN_STAGE+DIV_BITS+5];
	logic [63:0] pq13;
	logic [63:0] pp2_s80, e2p_s80, e2p_s81, e2p_s82, e1p_s82;
	logic [63:0] psum, pfin;
	logic [31:0] press_s83;
	logic        w1neg, numneg;

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s5 <= {{32{tf_s4[31]}}, tf_s4} - 64'd128000;
		end
	end

	scr_mul64 u_mul_xx  (.clk(clk), .en(adv), .a(x_s5), .b(x_s5), .p(xx_s7));
	scr_mul64 u_mul_xp5 (.clk(clk), .en(adv), .a(x_s5), .b(p5),   .p(xp5_s7));
	scr_mul64 u_mul_xp2 (.clk(clk), .en(adv), .a(x_s5), .b(p2),   .p(xp2_s7));
	scr_mul64 u_mul_p6  (.clk(clk), .en(adv), .a(xx_s7), .b(p6),  .p(xxp6_s9));
	scr_mul64 u_mul_p3  (.clk(clk), .en(adv), .a(xx_s7), .b(p3),  .p(xxp3_s9));

	always_ff @(posedge clk) begin
		if (adv) begin
			xp5_s8  <= xp5_s7;
			xp2_s8  <= xp2_s7;
			xp5_s9  <= xp5_s8;
			xp2_s9  <= xp2_s8;
			w2_s10  <= xxp6_s9 + (xp5_s9 << 17) + (p4 << 35);
			w1a_s10 <= asr64(xxp3_s9, 8) + (xp2_s9 << 12);
		end
	end

	assign num0 = ({43'd0, pr_dly_q[10]} << 31) - w2_s10;
	assign w1s  = 64'h0000_8000_0000_0000 + w1a_s10;

	scr_mul64 u_mul_num (.clk(clk), .en(adv), .a(num0), .b(64'd3125), .p(num_s12));
	scr_mul64 u_mul_p1  (.clk(clk), .en(adv), .a(w1s),  .b(p1),       .p(w1r_s12));

	assign w1     = asr64(w1r_s12, 33);
	assign w1neg  = w1[63];
	assign numneg = num_s12[63];

	always_ff @(posedge clk) begin
		if (adv) begin
			ua_s13 <= numneg ? 64'd0 - num_s12 : num_s12;
			ub_s13 <= w1neg ? 64'd0 - w1 : w1;
			zero_dly_q[DIV_IN_STAGE] <= (w1 == 64'd0);
			neg_dly_q[DIV_IN_STAGE]  <= numneg ^ w1neg;
			for (int k = DIV_IN_STAGE + 1; k <= PIPE_LAST - 1; k++) begin
				zero_dly_q[k] <= zero_dly_q[k-1];
			end
			for (int k = DIV_IN_STAGE + 1; k <= DIV_IN_STAGE + DIV_BITS; k++) begin
				neg_dly_q[k] <= neg_dly_q[k-1];
			end
		end
	end

	scr_div64 u_div (
		.clk      (clk),
		.en       (adv),
		.dividend (ua_s13),
		.divisor  (ub_s13),
		.quotient (uq)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			q_dly_q[DIV_IN_STAGE+DIV_BITS+1] <=
				neg_dly_q[DIV_IN_STAGE+DIV_BITS] ? 64'd0 - uq : uq;
			for (int k = DIV_IN_STAGE + DIV_BITS + 2; k <= DIV_IN_STAGE + DIV_BITS + 5; k++) begin
				q_dly_q[k] <= q_dly_q[k-1];
			end
		end
	end

	assign pq13 = asr64(q_dly_q[DIV_IN_STAGE+DIV_BITS+1], 13);

	scr_mul64 u_mul_pp (.clk(clk), .en(adv), .a(pq13), .b(pq13), .p(pp2_s80));
	scr_mul64 u_mul_p8 (.clk(clk), .en(adv), .a(q_dly_q[DIV_IN_STAGE+DIV_BITS+1]), .b(p8),
		.p(e2p_s80));
	scr_mul64 u_mul_p9 (.clk(clk), .en(adv), .a(pp2_s80), .b(p9), .p(e1p_s82));

	assign psum = q_dly_q[DIV_IN_STAGE+DIV_BITS+5] + asr64(e1p_s82, 25) + asr64(e2p_s82, 19);
	assign pfin = asr64(psum, 8) + (p7 << 4);

	always_ff @(posedge clk) begin
		if (adv) begin
			e2p_s81   <= e2p_s80;
			e2p_s82   <= e2p_s81;
			press_s83 <= zero_dly_q[PIPE_LAST-1] ? 32'd0 : pfin[31:0];
		end
	end

	// ---------------- output register and skid ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || !out_stall) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= vld_q[PIPE_LAST];
			end
		end else if (adv && vld_q[PIPE_LAST]) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || !out_stall) begin
			if (skid_v_q) begin
				out_temp_q  <= skid_temp_q;
				out_press_q <= skid_press_q;
				out_hum_q   <= skid_hum_q;
			end else begin
				out_temp_q  <= temp_dly_q[PIPE_LAST];
				out_press_q <= press_s83;
				out_hum_q   <= hum_dly_q[PIPE_LAST];
			end
		end else if (adv) begin
			skid_temp_q  <= temp_dly_q[PIPE_LAST];
			skid_press_q <= press_s83;
			skid_hum_q   <= hum_dly_q[PIPE_LAST];
		end
	end

	assign out_valid     = out_v_q;
	assign temp_centideg = out_temp_q;
	assign press_q24_8   = out_press_q;
	assign hum_q22_10    = out_hum_q;

endmodule

FILE: src/scr_mul64.sv
// Two-stage 64 x 64 multiplier returning the low 64 bits of the product.
// Built from three 32 x 32 partial products; no package dependencies.
`timescale 1ns / 1ps

module scr_mul64 (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] p
);

	logic [63:0] ll_q;
	logic [31:0] lh_q;
	logic [31:0] hl_q;
	logic [63:0] p_q;

	// The high by high product only reaches bit 64 and above, so it is dropped.
	always_ff @(posedge clk) begin
		if (en) begin
			ll_q <= {32'd0, a[31:0]} * {32'd0, b[31:0]};
			lh_q <= a[31:0] * b[63:32];
			hl_q <= a[63:32] * b[31:0];
			p_q  <= ll_q + {lh_q + hl_q, 32'd0};
		end
	end

	assign p = p_q;

endmodule

FILE: src/scr_div64.sv
// Fully pipelined unsigned 64-bit restoring divider, one quotient bit per stage.
// Depends on scr_pkg for the stage count.
`timescale 1ns / 1ps

module scr_div64 import scr_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic [63:0] quotient
);

	logic [63:0] rem_q [DIV_BITS];
	logic [63:0] dvd_q [DIV_BITS];
	logic [63:0] dsr_q [DIV_BITS];

	genvar k;
	for (k = 0; k < DIV_BITS; k++) begin : g_step
		logic [63:0] rem_in;
		logic [63:0] dvd_in;
		logic [63:0] dsr_in;
		logic [64:0] trial;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign dvd_in = dividend;
			assign dsr_in = divisor;
		end else begin : g_next
			assign rem_in = rem_q[k-1];
			assign dvd_in = dvd_q[k-1];
			assign dsr_in = dsr_q[k-1];
		end

		// The remainder stays below the divisor, so its top bit is always clear.
		assign trial = {rem_in, dvd_in[63]} - {1'b0, dsr_in};

		always_ff @(posedge clk) begin
			if (en) begin
				if (!trial[64]) begin
					rem_q[k] <= trial[63:0];
				end else begin
					rem_q[k] <= {rem_in[62:0], dvd_in[63]};
				end
				dvd_q[k] <= {dvd_in[62:0], ~trial[64]};
				dsr_q[k] <= dsr_in;
			end
		end
	end

	assign quotient = dvd_q[DIV_BITS-1];

endmodule

FILE: sim/tb.sv
// Self-checking testbench for sensor_raw_compensation: directed table, then random triples
// under several calibration sets, checked against a predictor of the compensation formulas.
// Depends on scr_pkg for the register indexes and on the RTL of the block.
`timescale 1ns / 1ps

module tb;
	import scr_pkg::*;

	typedef struct packed {
		logic [31:0] temp;
		logic [31:0] press;
		logic [16:0] hum;
	} comp_t;

	typedef struct {
		int unsigned cal_sel;
		logic [19:0] t;
		logic [19:0] p;
		logic [15:0] h;
		bit          typed;
		comp_t       want;
	} row_t;

	localparam int CAL_ZERO  = 0;
	localparam int CAL_TYP   = 1;
	localparam int CAL_ONES  = 2;
	localparam int CAL_NODIV = 3;
	localparam int CAL_RAND  = 4;
	localparam int CAL_JIT   = 5;
	localparam int LIMIT     = 400000;
	localparam int DRAIN     = 100;

	// Register index that has no register behind it.
	localparam logic [2:0] REG_UNUSED = 3'd5;

	localparam logic [47:0] TYP_TEMP  = {16'hFC18, 16'd26435, 16'd27504};
	localparam logic [63:0] TYP_PA    = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
	localparam logic [63:0] TYP_PB    = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
	localparam logic [15:0] TYP_P9    = 16'd6000;
	localparam logic [63:0] TYP_HUM   = {8'd30, 12'd50, 12'd324, 8'd0, 16'd362, 8'd75};

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite, pready;
	logic [5:0]  paddr;
	logic [63:0] pwdata, prdata;
	logic        in_valid, in_stall, out_valid, out_stall;
	logic [19:0] raw_temp, raw_press;
	logic [15:0] raw_hum;
	logic [31:0] temp_centideg, press_q24_8;
	logic [16:0] hum_q22_10;

	logic [47:0] cal_t;
	logic [63:0] cal_pa, cal_pb, cal_hm;
	logic [15:0] cal_p9;

	comp_t       pending_q[$];
	int          mism;
	int          cycles;
	int          n_in, n_out, n_cfg;
	bit          idle_en, hold_req;
	row_t        dir_rows[$];

	sensor_raw_compensation dut (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [31:0] sra32(input logic [31:0] v, input int unsigned n);
		return $unsigned($signed(v) >>> n);
	endfunction

	function automatic logic [63:0] sra64(input logic [63:0] v, input int unsigned n);
		return $unsigned($signed(v) >>> n);
	endfunction

	function automatic logic [63:0] quot_trunc(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] ua, ub, q;
		ua = a[63] ? -a : a;
		ub = b[63] ? -b : b;
		q = ua / ub;
		return (a[63] != b[63]) ? -q : q;
	endfunction

	// Compensates one raw triple with the calibration currently held by the testbench.
	function automatic comp_t compensate(input logic [19:0] at, input logic [19:0] ap,
			input logic [15:0] ah);
		logic [31:0] t1, t2, t3, d1, d2, va, vb, tf, v, a, b, s;
		logic [31:0] h1, h2, h3, h4, h5, h6;
		logic [63:0] x, w1, w2, pp, e1, e2;
		logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
		comp_t r;
		t1 = {16'd0, cal_t[15:0]};
		t2 = {{16{cal_t[31]}}, cal_t[31:16]};
		t3 = {{16{cal_t[47]}}, cal_t[47:32]};
		d1 = {12'd0, at} >> 3;
		d1 = d1 - (t1 << 1);
		va = sra32(d1 * t2, 11);
		d2 = ({12'd0, at} >> 4) - t1;
		vb = sra32(sra32(d2 * d2, 12) * t3, 14);
		tf = va + vb;
		r.temp = sra32(tf * 32'd5 + 32'd128, 8);

		p1 = {48'd0, cal_pa[15:0]};
		p2 = {{48{cal_pa[31]}}, cal_pa[31:16]};
		p3 = {{48{cal_pa[47]}}, cal_pa[47:32]};
		p4 = {{48{cal_pa[63]}}, cal_pa[63:48]};
		p5 = {{48{cal_pb[15]}}, cal_pb[15:0]};
		p6 = {{48{cal_pb[31]}}, cal_pb[31:16]};
		p7 = {{48{cal_pb[47]}}, cal_pb[47:32]};
		p8 = {{48{cal_pb[63]}}, cal_pb[63:48]};
		p9 = {{48{cal_p9[15]}}, cal_p9};
		x = {{32{tf[31]}}, tf} - 64'd128000;
		w2 = x * x * p6;
		w2 = w2 + ((x * p5) << 17);
		w2 = w2 + (p4 << 35);
		w1 = sra64(x * x * p3, 8) + ((x * p2) << 12);
		w1 = sra64(((64'd1 << 47) + w1) * p1, 33);
		if (w1 == 64'd0) begin
			r.press = 32'd0;
		end else begin
			pp = 64'd1048576 - {44'd0, ap};
			pp = quot_trunc(((pp << 31) - w2) * 64'd3125, w1);
			e1 = sra64(p9 * sra64(pp, 13) * sra64(pp, 13), 25);
			e2 = sra64(p8 * pp, 19);
			pp = sra64(pp + e1 + e2, 8) + (p7 << 4);
			r.press = pp[31:0];
		end

		h1 = {24'd0, cal_hm[7:0]};
		h2 = {{16{cal_hm[23]}}, cal_hm[23:8]};
		h3 = {24'd0, cal_hm[31:24]};
		h4 = {20'd0, cal_hm[43:32]};
		h5 = {20'd0, cal_hm[55:44]};
		h6 = {{24{cal_hm[63]}}, cal_hm[63:56]};
		v = tf - 32'd76800;
		a = sra32(({16'd0, ah} << 14) - (h4 << 20) - h5 * v + 32'd16384, 15);
		b = sra32(sra32(v * h6, 10) * (sra32(v * h3, 11) + 32'd32768), 10);
		b = sra32((b + 32'd2097152) * h2 + 32'd8192, 14);
		v = a * b;
		s = sra32(v, 15);
		v = v - sra32(sra32(s * s, 7) * h1, 4);
		// Negative values clamp to zero, large ones to the top of the range.
		if (v[31])
			v = 32'd0;
		else if (v > 32'd419430400)
			v = 32'd419430400;
		r.hum = v[28:12];
		return r;
	endfunction

	task automatic flag(input string what, input logic [63:0] want, input logic [63:0] got);
		mism++;
		if (mism <= 10)
			$display("MISMATCH %s: expected %h, got %h", what, want, got);
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
		logic [63:0] held, got;
		@(negedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= {idx, 3'b000}; pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		// A readable register goes straight on into the setup cycle of its read.
		penable <= 1'b0; pwrite <= 1'b0;
		if (idx > REG_CAL_HUM)
			psel <= 1'b0;
		n_cfg++;
		held = 64'd0;
		case (idx)
			REG_CAL_TEMP: begin cal_t = val[47:0]; held = {16'd0, cal_t}; end
			REG_CAL_PRESS_A: begin cal_pa = val; held = val; end
			REG_CAL_PRESS_B: begin cal_pb = val; held = val; end
			REG_CAL_PRESS_NINE: begin cal_p9 = val[15:0]; held = {48'd0, cal_p9}; end
			REG_CAL_HUM: begin cal_hm = val; held = val; end
			default: ;
		endcase
		if (idx <= REG_CAL_HUM) begin
			@(negedge clk);
			penable <= 1'b1;
			@(posedge clk);
			got = prdata;
			@(negedge clk);
			psel <= 1'b0; penable <= 1'b0;
			if (got !== held)
				flag("register readback", held, got);
		end
	endtask

	task automatic load_cal(input int sel);
		logic [63:0] j;
		j = {$urandom, $urandom};
		case (sel)
			CAL_ZERO: begin
				reg_write(REG_CAL_TEMP, 64'd0); reg_write(REG_CAL_PRESS_A, 64'd0);
				reg_write(REG_CAL_PRESS_B, 64'd0); reg_write(REG_CAL_PRESS_NINE, 64'd0);
				reg_write(REG_CAL_HUM, 64'd0);
			end
			CAL_ONES: begin
				reg_write(REG_CAL_TEMP, '1); reg_write(REG_CAL_PRESS_A, '1);
				reg_write(REG_CAL_PRESS_B, '1); reg_write(REG_CAL_PRESS_NINE, '1);
				reg_write(REG_CAL_HUM, '1);
			end
			CAL_RAND: begin
				reg_write(REG_CAL_TEMP, {$urandom, $urandom});
				reg_write(REG_CAL_PRESS_A, {$urandom, $urandom});
				reg_write(REG_CAL_PRESS_B, {$urandom, $urandom});
				reg_write(REG_CAL_PRESS_NINE, {$urandom, $urandom});
				reg_write(REG_CAL_HUM, {$urandom, $urandom});
			end
			default: begin
				// Typical coefficients; the jittered set flips a few low bits of each field.
				if (sel != CAL_JIT)
					j = 64'd0;
				reg_write(REG_CAL_TEMP, {16'd0, TYP_TEMP ^ j[47:0] & 48'h001F_003F_003F});
				reg_write(REG_CAL_PRESS_A, (sel == CAL_NODIV) ?
					{TYP_PA[63:16], 16'd0} : TYP_PA ^ (j & 64'h000F_000F_000F_00FF));
				reg_write(REG_CAL_PRESS_B, TYP_PB ^ (j & 64'h00FF_00FF_000F_000F));
				reg_write(REG_CAL_PRESS_NINE, {48'd0, TYP_P9 ^ j[31:16] & 16'h00FF});
				reg_write(REG_CAL_HUM, TYP_HUM ^ (j & 64'h0F00_F00F_0F0F_0F0F));
			end
		endcase
	endtask

	task automatic send_triple(input logic [19:0] t, input logic [19:0] p, input logic [15:0] h,
			input bit typed, input comp_t want);
		@(negedge clk);
		if (idle_en && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		in_valid <= 1'b1;
		raw_temp <= t; raw_press <= p; raw_hum <= h;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		pending_q = {pending_q, (typed ? want : compensate(t, p, h))};
		n_in++;
	endtask

	task automatic drain;
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	// Receiver: random stall bursts, or one long hold-off when asked.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (400) @(negedge clk);
				out_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (idle_en && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		comp_t exp_r;
		cycles++;
		if (cycles > LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			n_out++;
			if (pending_q.size() == 0) begin
				flag("unexpected result", 64'd0, {temp_centideg, press_q24_8});
			end else begin
				exp_r = pending_q.pop_front();
				if (temp_centideg !== exp_r.temp)
					flag("temp_centideg", exp_r.temp, temp_centideg);
				if (press_q24_8 !== exp_r.press)
					flag("press_q24_8", exp_r.press, press_q24_8);
				if (hum_q22_10 !== exp_r.hum)
					flag("hum_q22_10", exp_r.hum, hum_q22_10);
			end
		end
	end

	task automatic add_row(input int sel, input logic [19:0] t, input logic [19:0] p,
			input logic [15:0] h, input bit typed);
		row_t r;
		r.cal_sel = sel; r.t = t; r.p = p; r.h = h; r.typed = typed; r.want = '0;
		dir_rows = {dir_rows, r};
	endtask

	initial begin
		int cur_sel;
		logic [19:0] t, p;
		logic [15:0] h;
		mism = 0; cycles = 0; n_in = 0; n_out = 0; n_cfg = 0;
		idle_en = 1'b1; hold_req = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		in_valid = 1'b0; raw_temp = '0; raw_press = '0; raw_hum = '0;
		cal_t = '0; cal_pa = '0; cal_pb = '0; cal_p9 = '0; cal_hm = '0;

		// With every coefficient zero all three results are zero, pressure by zero divisor.
		add_row(CAL_ZERO, 20'h00000, 20'h00000, 16'h0000, 1'b1);
		add_row(CAL_ZERO, 20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b1);
		add_row(CAL_ZERO, 20'hAAAAA, 20'h55555, 16'hAAAA, 1'b1);
		add_row(CAL_ZERO, 20'h55555, 20'hAAAAA, 16'h5555, 1'b1);
		add_row(CAL_TYP, 20'd519888, 20'd415148, 16'd30000, 1'b0);
		add_row(CAL_TYP, 20'h00000, 20'h00000, 16'h0000, 1'b0);
		add_row(CAL_TYP, 20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b0);
		add_row(CAL_TYP, 20'd519888, 20'h00000, 16'hFFFF, 1'b0);
		add_row(CAL_TYP, 20'd519888, 20'hFFFFF, 16'h0000, 1'b0);
		add_row(CAL_TYP, 20'd400000, 20'd300000, 16'd20000, 1'b0);
		add_row(CAL_TYP, 20'd600000, 20'd500000, 16'd40000, 1'b0);
		add_row(CAL_TYP, 20'hAAAAA, 20'h55555, 16'hAAAA, 1'b0);
		add_row(CAL_NODIV, 20'd519888, 20'd415148, 16'd30000, 1'b0);
		add_row(CAL_NODIV, 20'hFFFFF, 20'h00000, 16'h0000, 1'b0);
		add_row(CAL_ONES, 20'h00000, 20'h00000, 16'h0000, 1'b0);
		add_row(CAL_ONES, 20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b0);
		add_row(CAL_ONES, 20'h55555, 20'hAAAAA, 16'h5555, 1'b0);
		add_row(CAL_ONES, 20'd519888, 20'd415148, 16'd30000, 1'b0);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		cur_sel = CAL_ZERO;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].cal_sel != cur_sel) begin
				drain();
				cur_sel = dir_rows[i].cal_sel;
				load_cal(cur_sel);
			end
			send_triple(dir_rows[i].t, dir_rows[i].p, dir_rows[i].h,
				dir_rows[i].typed, dir_rows[i].want);
		end
		drain();
		// An unused register index must leave the calibration alone.
		reg_write(REG_UNUSED, {$urandom, $urandom});

		for (int ph = 0; ph < 8; ph++) begin
			drain();
			case (ph % 4)
				0: load_cal(CAL_JIT);
				1: load_cal(CAL_RAND);
				2: load_cal(CAL_TYP);
				default: load_cal(CAL_JIT);
			endcase
			idle_en = (ph < 6);
			if (ph == 3) begin
				idle_en = 1'b0;
				hold_req = 1'b1;
			end
			for (int k = 0; k < 50; k++) begin
				if ($urandom_range(0, 1)) begin
					t = 20'($urandom_range(380000, 620000));
					p = 20'($urandom_range(200000, 600000));
					h = 16'($urandom_range(15000, 50000));
				end else begin
					t = 20'($urandom); p = 20'($urandom); h = 16'($urandom);
				end
				send_triple(t, p, h, 1'b0, '0);
			end
			if (ph == 3)
				idle_en = 1'b1;
		end
		drain();

		$display("Covered %0d triples, %0d results and %0d register writes,", n_in, n_out, n_cfg);
		$display("over zero, typical, jittered, random, all-ones and zero-divisor calibration.");
		if (mism == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches in total", mism);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
